[hdl/thr_pkg.sv]
// Shared constants, types and codes for the per-source connection throttle.
// Used by thr_cell, thr_upd and the top level; no dependencies.
package thr_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int TIME_BITS     = 48;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int ADDR_W        = 32;
    localparam int CNT_W         = 8;
    localparam int CFG_W         = 16;
    localparam int CIDX_W        = 3;
    localparam int STAT_W        = 3;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [STAT_W-1:0]    t_status;
    typedef logic [CIDX_W-1:0]    t_cfg_idx;

    localparam t_time TIME_MAX = '1;

    localparam t_status ST_NEW      = 3'd0;
    localparam t_status ST_ACCEPT   = 3'd1;
    localparam t_status ST_BLOCKED  = 3'd2;
    localparam t_status ST_NEWBLOCK = 3'd3;
    localparam t_status ST_FULL     = 3'd4;

    localparam t_cfg_idx CFG_BURST_WINDOW = 3'd0;
    localparam t_cfg_idx CFG_BURST_LIMIT  = 3'd1;
    localparam t_cfg_idx CFG_FAST_GAP     = 3'd2;
    localparam t_cfg_idx CFG_BLOCK        = 3'd3;
    localparam t_cfg_idx CFG_PENALTY      = 3'd4;

    localparam logic [CFG_W-1:0] DEF_BURST_WINDOW = 16'd5000;
    localparam logic [CNT_W-1:0] DEF_BURST_LIMIT  = 8'd5;
    localparam logic [CFG_W-1:0] DEF_FAST_GAP     = 16'd500;
    localparam logic [CFG_W-1:0] DEF_BLOCK        = 16'd3000;
    localparam logic [CFG_W-1:0] DEF_PENALTY      = 16'd250;

    typedef struct packed {
        logic [CFG_W-1:0] window;
        logic [CNT_W-1:0] limit;
        logic [CFG_W-1:0] fast;
        logic [CFG_W-1:0] blk;
        logic [CFG_W-1:0] pen;
    } t_cfg;

    // search word walking the cell chain
    typedef struct packed {
        logic             active;
        logic             found;
        logic             fresh;
        logic [IDX_W-1:0] idx;
        t_time            last;
        t_time            bu;
        logic [CNT_W-1:0] cnt;
    } t_word;

    // entry write-back broadcast to all cells
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_time            last;
        t_time            bu;
        logic [CNT_W-1:0] cnt;
    } t_wb;

endpackage

[hdl/per_source_connection_throttle_top.sv]
// Per-source connection throttle: a word passes r_inject, the cell chain walked one
// entry per cycle, thr_upd stages A and B and the result register. One word in flight;
// a new word is taken once the last result has moved to the output register.
// Reset (synchronous, active low) restores register defaults and clears all
// entry valid bits at once; no clearing pass. Depends on thr_pkg, thr_cell, thr_upd.
module per_source_connection_throttle_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [thr_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [thr_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [thr_pkg::ADDR_W-1:0]  i_source_addr,
    input  logic [thr_pkg::TIME_BITS-1:0] i_now_ms,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_accepted,
    output logic [thr_pkg::STAT_W-1:0]  o_status
);
    import thr_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_DONE
    } t_state;

    t_state            r_state;
    t_cfg              r_cfg;
    logic              r_inject;
    logic [ADDR_W-1:0] r_addr;
    t_time             r_now;
    logic              r_res_acc;
    t_status           r_res_status;
    logic              r_out_valid;
    logic              r_out_acc;
    t_status           r_out_status;

    t_word             w_head;
    t_word             w_chain [TABLE_ENTRIES];
    t_word             w_tail;
    t_wb               w_wb;
    logic              w_done;
    logic              w_acc;
    t_status           w_status;

    always_comb begin
        w_head        = '0;
        w_head.active = r_inject;
    end

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        if (g == 0) begin : g_first
            thr_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (IDX_W'(g)),
                .i_addr  (r_addr),
                .i_now   (r_now),
                .i_word  (w_head),
                .i_wb    (w_wb),
                .o_word  (w_chain[g])
            );
        end else begin : g_next
            thr_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (IDX_W'(g)),
                .i_addr  (r_addr),
                .i_now   (r_now),
                .i_word  (w_chain[g-1]),
                .i_wb    (w_wb),
                .o_word  (w_chain[g])
            );
        end
    end

    assign w_tail = w_chain[TABLE_ENTRIES-1];

    thr_upd u_upd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (w_tail),
        .i_now      (r_now),
        .i_cfg      (r_cfg),
        .o_done     (w_done),
        .o_accepted (w_acc),
        .o_status   (w_status),
        .o_wb       (w_wb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_inject      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cfg.window  <= DEF_BURST_WINDOW;
            r_cfg.limit   <= DEF_BURST_LIMIT;
            r_cfg.fast    <= DEF_FAST_GAP;
            r_cfg.blk     <= DEF_BLOCK;
            r_cfg.pen     <= DEF_PENALTY;
        end else begin
            r_inject <= (r_state == S_IDLE) && i_in_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BURST_WINDOW: r_cfg.window <= i_cfg_data;
                    CFG_BURST_LIMIT:  r_cfg.limit  <= i_cfg_data[CNT_W-1:0];
                    CFG_FAST_GAP:     r_cfg.fast   <= i_cfg_data;
                    CFG_BLOCK:        r_cfg.blk    <= i_cfg_data;
                    CFG_PENALTY:      r_cfg.pen    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_addr   <= i_source_addr;
                        r_now    <= i_now_ms;
                        r_state  <= S_BUSY;
                    end
                end
                S_BUSY: begin
                    if (w_done) begin
                        r_res_acc    <= w_acc;
                        r_res_status <= w_status;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_acc    <= r_res_acc;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_out_acc;
    assign o_status    = r_out_status;

    a_inject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inject |-> (r_state == S_BUSY))
        else $error("search word launched outside a lookup");

    a_tail_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.active |-> (r_state == S_BUSY))
        else $error("search word left the chain outside a lookup");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_BUSY))
        else $error("update finished outside a lookup");

endmodule

[hdl/thr_cell.sv]
// One table entry of the throttle plus its stage of the search chain.
// Depends on thr_pkg.
module thr_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [thr_pkg::IDX_W-1:0] i_idx,
    input  logic [thr_pkg::ADDR_W-1:0] i_addr,
    input  thr_pkg::t_time            i_now,
    input  thr_pkg::t_word            i_word,
    input  thr_pkg::t_wb              i_wb,
    output thr_pkg::t_word            o_word
);
    import thr_pkg::*;

    logic              r_valid;
    logic [ADDR_W-1:0] r_addr;
    t_time             r_last;
    t_time             r_bu;
    logic [CNT_W-1:0]  r_cnt;
    t_word             r_word;
    t_word             n_word;

    logic w_open;
    logic w_hit;
    logic w_claim;
    logic w_wb_sel;

    assign w_open   = i_word.active && !i_word.found;
    assign w_hit    = w_open && r_valid && (r_addr == i_addr);
    // valid entries form a prefix, so the first free cell means no hit
    assign w_claim  = w_open && !r_valid;
    assign w_wb_sel = i_wb.en && (i_wb.idx == i_idx);

    always_comb begin
        n_word = i_word;
        if (w_hit) begin
            n_word.found = 1'b1;
            n_word.fresh = 1'b0;
            n_word.idx   = i_idx;
            n_word.last  = r_last;
            n_word.bu    = r_bu;
            n_word.cnt   = r_cnt;
        end else if (w_claim) begin
            n_word.found = 1'b1;
            n_word.fresh = 1'b1;
            n_word.idx   = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_word  <= '0;
        end else begin
            r_word <= n_word;
            if (w_claim) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_claim) begin
            r_addr <= i_addr;
            r_last <= i_now;
            r_bu   <= '0;
            r_cnt  <= CNT_W'(1);
        end else if (w_wb_sel) begin
            r_last <= i_wb.last;
            r_bu   <= i_wb.bu;
            r_cnt  <= i_wb.cnt;
        end
    end

    assign o_word = r_word;

    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$fell(r_valid))
        else $error("table entry lost its valid bit");

    a_claim_wb_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_claim && w_wb_sel))
        else $error("write-back hit a free entry");

endmodule

[hdl/thr_upd.sv]
// Two-stage update unit: evaluates the entry found by the chain and
// produces the verdict and the entry write-back. Depends on thr_pkg.
module thr_upd (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  thr_pkg::t_word    i_word,
    input  thr_pkg::t_time    i_now,
    input  thr_pkg::t_cfg     i_cfg,
    output logic              o_done,
    output logic              o_accepted,
    output thr_pkg::t_status  o_status,
    output thr_pkg::t_wb      o_wb
);
    import thr_pkg::*;

    // stage A
    logic               r_a_vld;
    logic               r_a_found;
    logic               r_a_fresh;
    logic [IDX_W-1:0]   r_a_idx;
    t_time              r_a_last;
    t_time              r_a_bu;
    logic [CNT_W-1:0]   r_a_cnt;
    t_time              r_a_now;
    logic               r_a_blocked;
    logic [TIME_BITS:0] r_a_pen;
    logic [TIME_BITS:0] r_a_blk;
    t_time              r_a_gap;
    logic [CNT_W:0]     r_a_cnt1;

    // stage B
    logic               r_done;
    logic               r_acc;
    t_status            r_status;
    t_wb                r_wb;

    logic               n_acc;
    t_status            n_status;
    t_wb                n_wb;

    t_time              w_pen_sat;
    t_time              w_blk_sat;
    logic               w_neg;
    logic               w_in_win;
    logic               w_in_fast;
    logic               w_over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_word.active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word.active) begin
            r_a_found   <= i_word.found;
            r_a_fresh   <= i_word.fresh;
            r_a_idx     <= i_word.idx;
            r_a_last    <= i_word.last;
            r_a_bu      <= i_word.bu;
            r_a_cnt     <= i_word.cnt;
            r_a_now     <= i_now;
            r_a_blocked <= (i_word.bu > i_now);
            r_a_pen     <= {1'b0, i_word.bu} + (TIME_BITS + 1)'(i_cfg.pen);
            r_a_blk     <= {1'b0, i_now} + (TIME_BITS + 1)'(i_cfg.blk);
            r_a_gap     <= i_now - i_word.last;
            r_a_cnt1    <= {1'b0, i_word.cnt} + (CNT_W + 1)'(1);
        end
    end

    assign w_pen_sat = r_a_pen[TIME_BITS] ? TIME_MAX : r_a_pen[TIME_BITS-1:0];
    assign w_blk_sat = r_a_blk[TIME_BITS] ? TIME_MAX : r_a_blk[TIME_BITS-1:0];
    assign w_neg     = r_a_gap[TIME_BITS-1];
    assign w_in_win  = w_neg || ((r_a_gap[TIME_BITS-1:CFG_W] == '0)
                                 && (r_a_gap[CFG_W-1:0] <= i_cfg.window));
    assign w_in_fast = w_neg || ((r_a_gap[TIME_BITS-1:CFG_W] == '0)
                                 && (r_a_gap[CFG_W-1:0] <= i_cfg.fast));
    assign w_over    = (r_a_cnt1 > {1'b0, i_cfg.limit});

    always_comb begin
        n_acc       = 1'b1;
        n_status    = ST_ACCEPT;
        n_wb.en     = 1'b0;
        n_wb.idx    = r_a_idx;
        n_wb.last   = r_a_now;
        n_wb.bu     = r_a_bu;
        n_wb.cnt    = r_a_cnt;
        if (!r_a_found) begin
            n_status = ST_FULL;
        end else if (r_a_fresh) begin
            n_status = ST_NEW;
        end else if (r_a_blocked) begin
            // blocked entries keep their last-attempt time
            n_wb.en     = r_a_vld;
            n_wb.last   = r_a_last;
            n_wb.bu     = w_pen_sat;
            n_acc       = 1'b0;
            n_status    = ST_BLOCKED;
        end else begin
            n_wb.en = r_a_vld;
            if (w_in_win) begin
                if (w_over) begin
                    n_wb.cnt = '0;
                    if (w_in_fast) begin
                        n_wb.bu  = w_blk_sat;
                        n_acc    = 1'b0;
                        n_status = ST_NEWBLOCK;
                    end
                end else begin
                    n_wb.cnt = r_a_cnt1[CNT_W-1:0];
                end
            end else begin
                n_wb.cnt = CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
            r_wb   <= '0;
        end else begin
            r_done <= r_a_vld;
            r_wb   <= n_wb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_vld) begin
            r_acc    <= n_acc;
            r_status <= n_status;
        end
    end

    assign o_done     = r_done;
    assign o_accepted = r_acc;
    assign o_status   = r_status;
    assign o_wb       = r_wb;

endmodule

[sim/per_source_connection_throttle_top_tb.sv]
// Self-checking bench for per_source_connection_throttle_top: drives connection attempts,
// predicts each accept/refuse verdict and compares it with the block's result word.
// Depends on thr_pkg and the per_source_connection_throttle_top RTL.
`timescale 1ns / 100ps

module per_source_connection_throttle_top_tb;
    import thr_pkg::*;

    localparam int       POOL_SIZE   = 12;
    localparam int       LONG_HOLD   = 2000;
    localparam int       CFG_GUARD   = 4;
    localparam int       MAX_CYCLES  = 1500000;
    localparam t_cfg_idx CFG_UNUSED  = 3'd7;

    typedef enum logic [1:0] {JOB_WORD, JOB_SETTING, JOB_PAUSE} t_job_kind;

    typedef struct {
        t_job_kind         kind;
        logic [ADDR_W-1:0] addr;
        t_time             now;
        t_cfg_idx          idx;
        logic [CFG_W-1:0]  data;
        int                gap;
    } t_job;

    typedef struct {
        logic    accepted;
        t_status status;
    } t_verdict;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    t_cfg_idx             i_cfg_idx     = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic [ADDR_W-1:0]    i_source_addr = '0;
    t_time                i_now_ms      = '0;
    logic                 i_out_ready   = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_accepted;
    t_status              o_status;

    per_source_connection_throttle_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_source_addr (i_source_addr),
        .i_now_ms      (i_now_ms),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_accepted    (o_accepted),
        .o_status      (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // source table mirror and register copies
    logic              src_valid [TABLE_ENTRIES];
    logic [ADDR_W-1:0] src_addr  [TABLE_ENTRIES];
    t_time             src_last  [TABLE_ENTRIES];
    t_time             src_until [TABLE_ENTRIES];
    logic [CNT_W-1:0]  src_count [TABLE_ENTRIES];
    logic [CFG_W-1:0]  cfg_window;
    logic [CNT_W-1:0]  cfg_limit;
    logic [CFG_W-1:0]  cfg_fast;
    logic [CFG_W-1:0]  cfg_block;
    logic [CFG_W-1:0]  cfg_penalty;

    t_job              jobs[$];
    t_verdict          verdicts_due[$];
    bit                issued [bit [ADDR_W-1:0]];
    logic [ADDR_W-1:0] src_pool [POOL_SIZE];
    t_time             gen_ms;
    int                planned;
    int                words_sent;
    int                results_seen;
    int                setting_writes;
    int                errors;
    int                cycle_count;
    int                status_tally [5];

    function automatic t_time sat_sum(input t_time a, input logic [CFG_W-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + (TIME_BITS + 1)'(b);
        return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
    endfunction

    // signed gap: negative counts as within any limit
    function automatic logic gap_ok(input t_time gap, input logic [CFG_W-1:0] limit);
        return gap[TIME_BITS-1] || (gap <= t_time'(limit));
    endfunction

    function automatic t_verdict throttle_decide(input logic [ADDR_W-1:0] addr,
                                                 input t_time now);
        t_verdict       v;
        int             i;
        int             hit;
        int             slot;
        t_time          gap;
        logic [CNT_W:0] cnt;
        hit = -1;
        slot = -1;
        v.accepted = 1'b1;
        v.status = ST_ACCEPT;
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            if (src_valid[i]) begin
                if (hit < 0 && src_addr[i] == addr) hit = i;
            end else if (slot < 0) begin
                slot = i;
            end
        end
        if (hit < 0) begin
            if (slot < 0) begin
                v.status = ST_FULL;
            end else begin
                src_valid[slot] = 1'b1;
                src_addr[slot] = addr;
                src_last[slot] = now;
                src_until[slot] = '0;
                src_count[slot] = CNT_W'(1);
                v.status = ST_NEW;
            end
        end else if (src_until[hit] > now) begin
            src_until[hit] = sat_sum(src_until[hit], cfg_penalty);
            v.accepted = 1'b0;
            v.status = ST_BLOCKED;
        end else begin
            gap = now - src_last[hit];
            src_last[hit] = now;
            if (gap_ok(gap, cfg_window)) begin
                cnt = {1'b0, src_count[hit]} + (CNT_W + 1)'(1);
                if (cnt > {1'b0, cfg_limit}) begin
                    src_count[hit] = '0;
                    if (gap_ok(gap, cfg_fast)) begin
                        src_until[hit] = sat_sum(now, cfg_block);
                        v.accepted = 1'b0;
                        v.status = ST_NEWBLOCK;
                    end
                end else begin
                    src_count[hit] = cnt[CNT_W-1:0];
                end
            end else begin
                src_count[hit] = CNT_W'(1);
            end
        end
        return v;
    endfunction

    task automatic add_word(input logic [ADDR_W-1:0] addr, input t_time now);
        t_job j;
        j.kind = JOB_WORD;
        j.addr = addr;
        j.now = now;
        j.idx = '0;
        j.data = '0;
        // every fourth stretch of 64 words goes without sender gaps
        j.gap = (((planned / 64) % 4) == 3) ? 0 : $urandom_range(0, 16);
        jobs.push_back(j);
        issued[addr] = 1'b1;
        planned++;
    endtask

    task automatic add_setting(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        t_job j;
        j.kind = JOB_SETTING;
        j.addr = '0;
        j.now = '0;
        j.idx = idx;
        j.data = data;
        j.gap = 0;
        jobs.push_back(j);
    endtask

    task automatic add_pause();
        t_job j;
        j.kind = JOB_PAUSE;
        j.addr = '0;
        j.now = '0;
        j.idx = '0;
        j.data = '0;
        j.gap = 0;
        jobs.push_back(j);
    endtask

    task automatic load_defaults();
        add_setting(CFG_BURST_WINDOW, DEF_BURST_WINDOW);
        add_setting(CFG_BURST_LIMIT, CFG_W'(DEF_BURST_LIMIT));
        add_setting(CFG_FAST_GAP, DEF_FAST_GAP);
        add_setting(CFG_BLOCK, DEF_BLOCK);
        add_setting(CFG_PENALTY, DEF_PENALTY);
    endtask

    task automatic random_traffic(input int count, input int fresh_pct);
        int                left;
        int                run;
        int                k;
        int                sel;
        logic [ADDR_W-1:0] addr;
        left = count;
        while (left > 0) begin
            run = 1;
            if ($urandom_range(0, 99) < fresh_pct) begin
                do addr = $urandom; while (issued.exists(addr));
            end else begin
                addr = src_pool[$urandom_range(0, POOL_SIZE - 1)];
                if ($urandom_range(0, 1)) run = $urandom_range(2, 10);
            end
            for (k = 0; k < run && left > 0; k++) begin
                sel = $urandom_range(0, 99);
                if (k > 0) gen_ms += t_time'($urandom_range(0, 700));
                else if (sel < 55) gen_ms += t_time'($urandom_range(0, 3000));
                else if (sel < 80) gen_ms += t_time'($urandom_range(0, 12000));
                else if (sel < 90) gen_ms += t_time'($urandom_range(0, 80000));
                else if (sel < 95) gen_ms -= t_time'($urandom_range(1, 3000));
                else if (sel < 98) gen_ms += t_time'($urandom) << $urandom_range(0, 16);
                else gen_ms = t_time'({$urandom, $urandom});
                add_word(addr, gen_ms);
                left--;
            end
        end
    endtask

    always @(posedge i_clk) begin : word_driver
        t_job head;
        logic valid_nxt;
        logic we_nxt;
        int   i;
        int   gap_cnt;
        int   settle_cnt;
        valid_nxt = i_in_valid;
        we_nxt = 1'b0;
        if (!i_rst_n) begin
            for (i = 0; i < TABLE_ENTRIES; i++) src_valid[i] = 1'b0;
            cfg_window = DEF_BURST_WINDOW;
            cfg_limit = DEF_BURST_LIMIT;
            cfg_fast = DEF_FAST_GAP;
            cfg_block = DEF_BLOCK;
            cfg_penalty = DEF_PENALTY;
            gap_cnt = 0;
            settle_cnt = 0;
            valid_nxt = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                verdicts_due.push_back(throttle_decide(i_source_addr, i_now_ms));
                words_sent++;
                valid_nxt = 1'b0;
            end
            if (results_seen == words_sent) settle_cnt++;
            else settle_cnt = 0;
            if (!valid_nxt && jobs.size() > 0) begin
                head = jobs[0];
                case (head.kind)
                    JOB_WORD: begin
                        if (gap_cnt < head.gap) begin
                            gap_cnt++;
                        end else begin
                            gap_cnt = 0;
                            valid_nxt = 1'b1;
                            i_source_addr <= head.addr;
                            i_now_ms <= head.now;
                            void'(jobs.pop_front());
                        end
                    end
                    JOB_PAUSE: begin
                        if (settle_cnt > 0) void'(jobs.pop_front());
                    end
                    JOB_SETTING: begin
                        if (settle_cnt >= CFG_GUARD) begin
                            we_nxt = 1'b1;
                            i_cfg_idx <= head.idx;
                            i_cfg_data <= head.data;
                            case (head.idx)
                                CFG_BURST_WINDOW: cfg_window = head.data;
                                CFG_BURST_LIMIT:  cfg_limit = head.data[CNT_W-1:0];
                                CFG_FAST_GAP:     cfg_fast = head.data;
                                CFG_BLOCK:        cfg_block = head.data;
                                CFG_PENALTY:      cfg_penalty = head.data;
                                default: ;
                            endcase
                            setting_writes++;
                            void'(jobs.pop_front());
                        end
                    end
                    default: ;
                endcase
            end
        end
        i_in_valid <= valid_nxt;
        i_cfg_we <= we_nxt;
    end

    always @(posedge i_clk) begin : result_monitor
        t_verdict want;
        logic     ready_nxt;
        int       n_seen;
        int       hold_left;
        if (!i_rst_n) begin
            n_seen = 0;
            hold_left = 0;
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_seen++;
                if (verdicts_due.size() == 0) begin
                    $error("unexpected result word: accepted=%0d status=%0d",
                           o_accepted, o_status);
                    errors++;
                end else begin
                    want = verdicts_due.pop_front();
                    status_tally[want.status]++;
                    if (o_accepted !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d", want.accepted, o_accepted);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        errors++;
                    end
                end
                results_seen <= n_seen;
                if (n_seen == 150 || n_seen == 650) hold_left = LONG_HOLD;
                else if (((n_seen / 80) % 5) == 2) hold_left = 0;
                else hold_left = $urandom_range(0, 16);
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_nxt = 1'b0;
            end else begin
                ready_nxt = 1'b1;
            end
            i_out_ready <= ready_nxt;
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= MAX_CYCLES) begin
            $display("per_source_connection_throttle_top test failed");
            $finish;
        end
    end

    initial begin : stimulus
        int i;
        src_pool[0] = '0;
        src_pool[1] = '1;
        src_pool[2] = 32'h0A00_0001;
        for (i = 3; i < POOL_SIZE; i++) src_pool[i] = $urandom;

        // burst on one source up to a fast block, then refusal and recovery
        add_word('0, 48'd0);
        add_word('1, TIME_MAX);
        for (i = 1; i <= 5; i++) add_word('0, t_time'(i * 100));
        add_word('0, 48'd600);
        add_word('0, 48'd10000);
        add_word('0, 48'd5000);
        // slow burst past the limit, then gaps right at and past the window
        for (i = 0; i < 6; i++) add_word(32'h0A00_0001, t_time'(20000 + i * 600));
        add_word(32'h0A00_0001, 48'd28000);
        add_word(32'h0A00_0001, 48'd33001);
        // saturating block and penalty at the top of the time range
        add_setting(CFG_BURST_LIMIT, 16'd1);
        add_setting(CFG_BLOCK, 16'hFFFF);
        add_word('1, TIME_MAX - 5);
        add_word('1, TIME_MAX - 1);
        add_word('1, TIME_MAX);

        load_defaults();
        gen_ms = 48'd100000;
        random_traffic(100, 6);
        add_pause();
        random_traffic(100, 6);

        add_setting(CFG_BURST_WINDOW, 16'hFFFF);
        add_setting(CFG_BURST_LIMIT, 16'd1);
        add_setting(CFG_FAST_GAP, 16'hFFFF);
        add_setting(CFG_BLOCK, 16'd0);
        add_setting(CFG_PENALTY, 16'd0);
        random_traffic(120, 4);

        add_setting(CFG_BURST_WINDOW, 16'd0);
        add_setting(CFG_BURST_LIMIT, 16'd0);
        add_setting(CFG_FAST_GAP, 16'd0);
        add_setting(CFG_BLOCK, 16'hFFFF);
        add_setting(CFG_PENALTY, 16'hFFFF);
        random_traffic(120, 4);

        add_setting(CFG_BURST_WINDOW, 16'd2000);
        add_setting(CFG_BURST_LIMIT, 16'd255);
        add_setting(CFG_FAST_GAP, 16'd1500);
        add_setting(CFG_BLOCK, 16'd500);
        add_setting(CFG_PENALTY, 16'd100);
        add_setting(CFG_UNUSED, 16'd1);
        random_traffic(120, 4);

        for (i = 0; i < 3; i++) begin
            add_setting(CFG_BURST_WINDOW, CFG_W'($urandom));
            add_setting(CFG_BURST_LIMIT, CFG_W'($urandom));
            add_setting(CFG_FAST_GAP, CFG_W'($urandom));
            add_setting(CFG_BLOCK, CFG_W'($urandom_range(0, 8000)));
            add_setting(CFG_PENALTY, CFG_W'($urandom_range(0, 2000)));
            random_traffic(45, 5);
        end

        // fill the table, then keep going past full
        load_defaults();
        while (issued.num() < TABLE_ENTRIES + 30) random_traffic(10, 90);
        random_traffic(60, 10);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (jobs.size() > 0 || i_in_valid || verdicts_due.size() > 0) @(negedge i_clk);
        repeat (TABLE_ENTRIES + 8) @(negedge i_clk);
        $display("%0d words checked across %0d register writes; new %0d, accepted %0d,",
                 words_sent, setting_writes, status_tally[ST_NEW], status_tally[ST_ACCEPT]);
        $display("refused while blocked %0d, newly blocked %0d, table full %0d",
                 status_tally[ST_BLOCKED], status_tally[ST_NEWBLOCK], status_tally[ST_FULL]);
        if (errors == 0) begin
            $display("per_source_connection_throttle_top test passed");
        end else begin
            $display("per_source_connection_throttle_top test failed");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/thr_pkg.sv
hdl/thr_cell.sv
hdl/thr_upd.sv
hdl/per_source_connection_throttle_top.sv
sim/per_source_connection_throttle_top_tb.sv
